FILE: rtl/pwlc_pkg.sv
// pwlc_pkg: shared widths, constants and beat types of the piecewise linear compressor
// no dependencies; imported by pwlc_dev_unit and piecewise_linear_compressor
`default_nettype none

package pwlc_pkg;

   localparam int TIME_BITS   = 48;
   localparam int VALUE_BITS  = 32;
   localparam int RATIO_BITS  = 16;
   localparam int FRAC_SHIFT  = 16;

   localparam logic [RATIO_BITS-1:0] RATIO_RESET = 16'd3277;

   typedef struct packed {
      logic [TIME_BITS-1:0]         sample_time;
      logic signed [VALUE_BITS-1:0] sample_value;
      logic                         series_end;
   } pwlc_req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]         kept_time;
      logic signed [VALUE_BITS-1:0] kept_value;
      logic                         item_done;
      logic                         series_done;
   } pwlc_rsp_type;

   typedef struct packed {
      logic done;
      logic brk;
   } pwlc_dev_status_type;

endpackage

`default_nettype wire

FILE: rtl/pwlc_dev_unit.sv
// pwlc_dev_unit: iterative cross-multiplied deviation test, one time bit per cycle
// depends on pwlc_pkg
`default_nettype none

module pwlc_dev_unit
   import pwlc_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [RATIO_BITS-1:0]        ratio,
   input  wire logic [TIME_BITS-1:0]         anchor_time,
   input  wire logic signed [VALUE_BITS-1:0] anchor_value,
   input  wire logic [TIME_BITS-1:0]         prev_time,
   input  wire logic signed [VALUE_BITS-1:0] prev_value,
   input  wire logic [TIME_BITS-1:0]         cur_time,
   input  wire logic signed [VALUE_BITS-1:0] cur_value,
   output pwlc_dev_status_type               status
);

   localparam int TB    = TIME_BITS;
   localparam int VB    = VALUE_BITS;
   localparam int KW    = VB + RATIO_BITS;
   localparam int RW    = KW + TB;
   localparam int DW    = VB + TB + 3;
   localparam int PADW  = DW + FRAC_SHIFT - RW;
   localparam int CNTW  = $clog2(TB);

   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_RUN  = 2'd1;
   localparam logic [1:0] P_ABS  = 2'd2;
   localparam logic [1:0] P_CMP  = 2'd3;

   logic [1:0]          phase_ff, phase_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [TB-1:0]       mdx_ff, mdx_in;
   logic [TB-1:0]       mex_ff, mex_in;
   logic [VB+1:0]       sdcur_ff, sdcur_in;
   logic [VB+1:0]       sdprev_ff, sdprev_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [DW-1:0]       d_ff, d_in;
   logic [RW-1:0]       r_ff, r_in;
   pwlc_dev_status_type status_ff, status_in;

   logic          dx_neg, ex_neg;
   logic [VB:0]   dcur, dprev;
   logic [VB+1:0] dcur_x, dprev_x;
   logic [VB-1:0] amag;
   logic [VB+2:0] term_a, term_b, term;

   // setup: differences, signs and anchor magnitude
   always_comb begin
      dx_neg  = prev_time < anchor_time;
      ex_neg  = cur_time < anchor_time;
      dcur    = {cur_value[VB-1], cur_value} - {anchor_value[VB-1], anchor_value};
      dprev   = {prev_value[VB-1], prev_value} - {anchor_value[VB-1], anchor_value};
      dcur_x  = {dcur[VB], dcur};
      dprev_x = {dprev[VB], dprev};
      amag    = anchor_value[VB-1] ? (~anchor_value + 1'b1) : anchor_value;
   end

   // msb-first shift-add step
   always_comb begin
      term_a = mdx_ff[TB-1] ? {sdcur_ff[VB+1], sdcur_ff} : '0;
      term_b = mex_ff[TB-1] ? {sdprev_ff[VB+1], sdprev_ff} : '0;
      term   = term_a - term_b;
   end

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      mdx_in    = mdx_ff;
      mex_in    = mex_ff;
      sdcur_in  = sdcur_ff;
      sdprev_in = sdprev_ff;
      k_in      = k_ff;
      d_in      = d_ff;
      r_in      = r_ff;
      status_in = '0;
      case (phase_ff)
         P_IDLE: begin
            if (start) begin
               mdx_in    = dx_neg ? (anchor_time - prev_time) : (prev_time - anchor_time);
               mex_in    = ex_neg ? (anchor_time - cur_time) : (cur_time - anchor_time);
               sdcur_in  = dx_neg ? (~dcur_x + 1'b1) : dcur_x;
               sdprev_in = ex_neg ? (~dprev_x + 1'b1) : dprev_x;
               k_in      = ratio * amag;
               d_in      = '0;
               r_in      = '0;
               cnt_in    = CNTW'(TB - 1);
               phase_in  = P_RUN;
            end
         end
         P_RUN: begin
            d_in   = {d_ff[DW-2:0], 1'b0} + {{(DW-VB-3){term[VB+2]}}, term};
            r_in   = {r_ff[RW-2:0], 1'b0} + (mdx_ff[TB-1] ? {{TB{1'b0}}, k_ff} : '0);
            mdx_in = {mdx_ff[TB-2:0], 1'b0};
            mex_in = {mex_ff[TB-2:0], 1'b0};
            if (cnt_ff == '0) begin
               phase_in = P_ABS;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         P_ABS: begin
            d_in     = d_ff[DW-1] ? (~d_ff + 1'b1) : d_ff;
            phase_in = P_CMP;
         end
         P_CMP: begin
            status_in.done = 1'b1;
            status_in.brk  = {d_ff, {FRAC_SHIFT{1'b0}}} > {{PADW{1'b0}}, r_ff};
            phase_in       = P_IDLE;
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= P_IDLE;
         status_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
      end
      cnt_ff    <= cnt_in;
      mdx_ff    <= mdx_in;
      mex_ff    <= mex_in;
      sdcur_ff  <= sdcur_in;
      sdprev_ff <= sdprev_in;
      k_ff      <= k_in;
      d_ff      <= d_in;
      r_ff      <= r_in;
   end

   assign status = status_ff;

endmodule

`default_nettype wire

FILE: rtl/piecewise_linear_compressor.sv
// piecewise_linear_compressor: key-point selector for a time series, top level
// depends on pwlc_pkg and pwlc_dev_unit
//
//   channel  direction  handshake                 beat
//   req      in         req_valid / req_ready     pwlc_req_type
//   rsp      out        rsp_valid / rsp_ready     pwlc_rsp_type
//   csr      in         csr_wr_en                 deviation_ratio, 16 bits
//
// a point that follows two or more points of its series runs the deviation unit, one
// bit of both time differences per cycle, then an absolute value and a compare; a first
// point, or a second that ends its series, skips it and is sent as a result beat
// synchronous active-high reset, no clearing pass; req_ready is high only while idle,
// and a result beat holds in the output register until rsp_ready takes it
`default_nettype none

module piecewise_linear_compressor
   import pwlc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pwlc_req_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pwlc_rsp_type               rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [RATIO_BITS-1:0] csr_wr_data
);

   localparam logic [1:0] S_IDLE      = 2'd0;
   localparam logic [1:0] S_EVAL      = 2'd1;
   localparam logic [1:0] S_EMIT_PREV = 2'd2;
   localparam logic [1:0] S_EMIT_CUR  = 2'd3;

   localparam logic [1:0] PS_START = 2'd0;
   localparam logic [1:0] PS_ONE   = 2'd1;
   localparam logic [1:0] PS_MORE  = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [1:0]                  ps_ff, ps_in;
   logic [RATIO_BITS-1:0]       ratio_ff, ratio_in;
   logic [TIME_BITS-1:0]        anchor_time_ff, anchor_time_in;
   logic signed [VALUE_BITS-1:0] anchor_value_ff, anchor_value_in;
   logic [TIME_BITS-1:0]        prev_time_ff, prev_time_in;
   logic signed [VALUE_BITS-1:0] prev_value_ff, prev_value_in;
   logic [TIME_BITS-1:0]        cur_time_ff, cur_time_in;
   logic signed [VALUE_BITS-1:0] cur_value_ff, cur_value_in;
   logic                        cur_end_ff, cur_end_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pwlc_rsp_type                rsp_data_ff, rsp_data_in;

   logic                unit_start;
   logic                slot_free;
   pwlc_dev_status_type dev_status;

   pwlc_dev_unit u_dev (
      .clock        (clock),
      .reset        (reset),
      .start        (unit_start),
      .ratio        (ratio_ff),
      .anchor_time  (anchor_time_ff),
      .anchor_value (anchor_value_ff),
      .prev_time    (prev_time_ff),
      .prev_value   (prev_value_ff),
      .cur_time     (req_data.sample_time),
      .cur_value    (req_data.sample_value),
      .status       (dev_status)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in        = state_ff;
      ps_in           = ps_ff;
      ratio_in        = csr_wr_en ? csr_wr_data : ratio_ff;
      anchor_time_in  = anchor_time_ff;
      anchor_value_in = anchor_value_ff;
      prev_time_in    = prev_time_ff;
      prev_value_in   = prev_value_ff;
      cur_time_in     = cur_time_ff;
      cur_value_in    = cur_value_ff;
      cur_end_in      = cur_end_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      unit_start      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_time_in  = req_data.sample_time;
               cur_value_in = req_data.sample_value;
               cur_end_in   = req_data.series_end;
               if (ps_ff == PS_START) begin
                  anchor_time_in  = req_data.sample_time;
                  anchor_value_in = req_data.sample_value;
                  prev_time_in    = req_data.sample_time;
                  prev_value_in   = req_data.sample_value;
                  ps_in           = req_data.series_end ? PS_START : PS_ONE;
                  state_in        = S_EMIT_CUR;
               end else if (ps_ff == PS_ONE) begin
                  if (req_data.series_end) begin
                     ps_in    = PS_START;
                     state_in = S_EMIT_CUR;
                  end else begin
                     prev_time_in  = req_data.sample_time;
                     prev_value_in = req_data.sample_value;
                     ps_in         = PS_MORE;
                  end
               end else begin
                  unit_start = 1'b1;
                  state_in   = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            if (dev_status.done) begin
               // on a break the old previous point becomes the anchor and is sent from there
               if (dev_status.brk) begin
                  anchor_time_in  = prev_time_ff;
                  anchor_value_in = prev_value_ff;
               end
               prev_time_in  = cur_time_ff;
               prev_value_in = cur_value_ff;
               ps_in         = cur_end_ff ? PS_START : PS_MORE;
               if (dev_status.brk) begin
                  state_in = S_EMIT_PREV;
               end else if (cur_end_ff) begin
                  state_in = S_EMIT_CUR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT_PREV: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kept_time   = anchor_time_ff;
               rsp_data_in.kept_value  = anchor_value_ff;
               rsp_data_in.item_done   = !cur_end_ff;
               rsp_data_in.series_done = 1'b0;
               state_in                = cur_end_ff ? S_EMIT_CUR : S_IDLE;
            end
         end
         S_EMIT_CUR: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kept_time   = cur_time_ff;
               rsp_data_in.kept_value  = cur_value_ff;
               rsp_data_in.item_done   = 1'b1;
               rsp_data_in.series_done = cur_end_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ps_ff        <= PS_START;
         ratio_ff     <= RATIO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ps_ff        <= ps_in;
         ratio_ff     <= ratio_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      anchor_time_ff  <= anchor_time_in;
      anchor_value_ff <= anchor_value_in;
      prev_time_ff    <= prev_time_in;
      prev_value_ff   <= prev_value_in;
      cur_time_ff     <= cur_time_in;
      cur_value_ff    <= cur_value_in;
      cur_end_ff      <= cur_end_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_done_in_eval: assert property (@(posedge clock) disable iff (reset)
      dev_status.done |-> state_ff == S_EVAL)
      else $error("deviation result outside evaluation");

   a_first_point_kept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && ps_ff == PS_START) |=> state_ff == S_EMIT_CUR)
      else $error("first point of series not sent");

   a_series_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.series_done || rsp_data.item_done))
      else $error("series end beat without item end");
`endif

endmodule

`default_nettype wire

FILE: test/tb_piecewise_linear_compressor.sv
`timescale 1ns / 1ps
// tb_piecewise_linear_compressor: self-checking bench for the key-point selector
// a scoreboard class predicts kept points from accepted samples and checks result beats
// depends on pwlc_pkg and the piecewise_linear_compressor rtl

class keypoint_scoreboard;
   typedef enum logic [1:0] {SERIES_START, ONE_POINT, RUNNING} series_phase_type;

   pwlc_pkg::pwlc_rsp_type                 pending[$];
   logic [pwlc_pkg::RATIO_BITS-1:0]        ratio;
   logic [pwlc_pkg::TIME_BITS-1:0]         anchor_time;
   logic [pwlc_pkg::TIME_BITS-1:0]         prev_time;
   logic signed [pwlc_pkg::VALUE_BITS-1:0] anchor_value;
   logic signed [pwlc_pkg::VALUE_BITS-1:0] prev_value;
   series_phase_type                       phase;
   int unsigned                            mismatches;
   int unsigned                            keys_checked;

   function new();
      ratio        = pwlc_pkg::RATIO_RESET;
      anchor_time  = '0;
      prev_time    = '0;
      anchor_value = '0;
      prev_value   = '0;
      phase        = SERIES_START;
      mismatches   = 0;
      keys_checked = 0;
   endfunction

   function void add_key(logic [pwlc_pkg::TIME_BITS-1:0] t,
                         logic signed [pwlc_pkg::VALUE_BITS-1:0] v,
                         logic item_last, logic series_last);
      pwlc_pkg::pwlc_rsp_type k;
      k.kept_time   = t;
      k.kept_value  = v;
      k.item_done   = item_last;
      k.series_done = series_last;
      pending.push_back(k);
   endfunction

   // exact cross-multiplied deviation test, 128 bits is ample headroom
   function bit line_broken(logic [pwlc_pkg::TIME_BITS-1:0] t,
                            logic signed [pwlc_pkg::VALUE_BITS-1:0] v);
      logic signed [127:0] at, pt, ct, dx, ex, dcur, dprev, dev, mag_y1, mdx, lhs, rhs;
      at     = 128'(anchor_time);
      pt     = 128'(prev_time);
      ct     = 128'(t);
      dx     = pt - at;
      ex     = ct - at;
      dcur   = 128'(v) - 128'(anchor_value);
      dprev  = 128'(prev_value) - 128'(anchor_value);
      dev    = dcur * dx - dprev * ex;
      if (dev < 0) dev = -dev;
      mag_y1 = 128'(anchor_value);
      if (mag_y1 < 0) mag_y1 = -mag_y1;
      mdx    = (dx < 0) ? -dx : dx;
      lhs    = dev <<< 16;
      rhs    = 128'(ratio);
      rhs    = rhs * mag_y1 * mdx;
      return lhs > rhs;
   endfunction

   function void note_point(pwlc_pkg::pwlc_req_type p);
      case (phase)
         SERIES_START: begin
            anchor_time  = p.sample_time;
            anchor_value = p.sample_value;
            prev_time    = p.sample_time;
            prev_value   = p.sample_value;
            add_key(p.sample_time, p.sample_value, 1'b1, p.series_end);
            phase = p.series_end ? SERIES_START : ONE_POINT;
         end
         ONE_POINT: begin
            if (p.series_end) begin
               add_key(p.sample_time, p.sample_value, 1'b1, 1'b1);
               phase = SERIES_START;
            end else begin
               prev_time  = p.sample_time;
               prev_value = p.sample_value;
               phase      = RUNNING;
            end
         end
         default: begin
            if (line_broken(p.sample_time, p.sample_value)) begin
               add_key(prev_time, prev_value, !p.series_end, 1'b0);
               anchor_time  = prev_time;
               anchor_value = prev_value;
            end
            prev_time  = p.sample_time;
            prev_value = p.sample_value;
            if (p.series_end) begin
               add_key(p.sample_time, p.sample_value, 1'b1, 1'b1);
               phase = SERIES_START;
            end else begin
               phase = RUNNING;
            end
         end
      endcase
   endfunction

   function void check_key(pwlc_pkg::pwlc_rsp_type got);
      pwlc_pkg::pwlc_rsp_type want;
      keys_checked++;
      if (pending.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected key point t=%0d v=%0d item=%0b series=%0b", $time,
                  got.kept_time, got.kept_value, got.item_done, got.series_done);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         mismatches++;
         $display("%0t: key point mismatch, expected t=%0d v=%0d item=%0b series=%0b",
                  $time, want.kept_time, want.kept_value, want.item_done, want.series_done);
         $display("%0t:                         actual t=%0d v=%0d item=%0b series=%0b",
                  $time, got.kept_time, got.kept_value, got.item_done, got.series_done);
      end
   endfunction
endclass

module tb_piecewise_linear_compressor;
   import pwlc_pkg::*;

   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_POINTS  = 93;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   pwlc_req_type          req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   pwlc_rsp_type          rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [RATIO_BITS-1:0] csr_wr_data = '0;

   keypoint_scoreboard key_model = new();

   int unsigned points_sent   = 0;
   int unsigned series_count  = 0;
   int unsigned send_gap_max  = 19;
   int unsigned ready_hold    = 0;
   bit          rsp_stall_on  = 1'b1;

   piecewise_linear_compressor dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: stalls drawn per beat, with stretches of none
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold = ready_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         key_model.check_key(rsp_data);
         if ($urandom_range(0, 39) == 0) rsp_stall_on = !rsp_stall_on;
         ready_hold = rsp_stall_on ? $urandom_range(0, 19) : 0;
      end
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_point(input logic [TIME_BITS-1:0] t,
                             input logic signed [VALUE_BITS-1:0] v, input logic last);
      pwlc_req_type p;
      int unsigned  gap;
      p.sample_time  = t;
      p.sample_value = v;
      p.series_end   = last;
      gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= p;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      key_model.note_point(p);
      points_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained(input bit settle);
      req_valid <= 1'b0;
      do @(negedge clock); while (key_model.pending.size() != 0);
      if (settle) repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_ratio(input logic [RATIO_BITS-1:0] r);
      req_valid   <= 1'b0;
      csr_wr_data <= r;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      key_model.ratio = r;
   endtask

   // one complete series: mostly noisy ramps, some random and extreme points
   task automatic run_series();
      int unsigned          len, style, i;
      longint               base, slope, amp, e, step, noise;
      logic [TIME_BITS-1:0] t, pt;
      logic [VALUE_BITS-1:0] pv;
      len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      style = $urandom_range(0, 9);
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      base  = longint'($signed($urandom)) >>> $urandom_range(4, 20);
      slope = longint'($signed($urandom)) >>> $urandom_range(16, 30);
      amp   = ($urandom_range(0, 2) == 0) ? 0 : (longint'(1) << $urandom_range(0, 20));
      t     = TIME_BITS'({$urandom, $urandom});
      e     = 0;
      series_count++;
      if ($urandom_range(0, 7) == 0) wait_drained(1'b0);
      for (i = 0; i < len; i++) begin
         if (style >= 8) begin
            pt = TIME_BITS'({$urandom, $urandom});
            pv = $urandom;
         end else if (style == 7) begin
            case ($urandom_range(0, 3))
               0:       pt = '0;
               1:       pt = '1;
               2:       pt = t;
               default: pt = TIME_BITS'({$urandom, $urandom});
            endcase
            case ($urandom_range(0, 4))
               0:       pv = 32'h8000_0000;
               1:       pv = 32'h7FFF_FFFF;
               2:       pv = '0;
               3:       pv = '1;
               default: pv = $urandom;
            endcase
         end else begin
            case ($urandom_range(0, 19))
               0:       step = 0;
               1:       step = -longint'($urandom_range(1, 500));
               default: step = longint'($urandom_range(1, 1000));
            endcase
            if (i > 0) begin
               e = e + step;
               t = t + TIME_BITS'(step);
            end
            noise = (amp == 0) ? 0 : longint'($urandom_range(0, 32'(2 * amp))) - amp;
            pt = t;
            pv = VALUE_BITS'(base + slope * e + noise);
         end
         send_point(pt, pv, i == len - 1);
      end
   endtask

   initial begin
      int unsigned           phase, phase_start;
      logic [RATIO_BITS-1:0] r;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // lone points at both extremes
      send_point('0, 32'sd0, 1'b1);
      send_point(48'hFFFF_FFFF_FFFF, 32'sh8000_0000, 1'b1);
      // two-point series
      send_point(48'd100, 32'sh7FFF_FFFF, 1'b0);
      send_point(48'd200, 32'sh8000_0000, 1'b1);
      // straight run, a break, then an end that breaks again
      send_point(48'd0, 32'sh0001_0000, 1'b0);
      send_point(48'd10, 32'sh0002_0000, 1'b0);
      send_point(48'd20, 32'sh0003_0000, 1'b0);
      send_point(48'd30, 32'sh0064_0000, 1'b0);
      send_point(48'd40, 32'sh0000_0000, 1'b1);
      // anchor and previous on the same timestamp
      send_point(48'd50, 32'sh0005_0000, 1'b0);
      send_point(48'd50, 32'sh0006_0000, 1'b0);
      send_point(48'd60, 32'sh0007_0000, 1'b1);
      // timestamps running backward
      send_point(48'd1000, 32'sh000A_0000, 1'b0);
      send_point(48'd900, 32'sh0014_0000, 1'b0);
      send_point(48'd800, 32'sh001E_0000, 1'b0);
      send_point(48'd700, 32'sh002D_0000, 1'b1);
      // zero anchor value and full-range time jumps
      send_point(48'd0, 32'sd0, 1'b0);
      send_point(48'hFFFF_FFFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
      send_point(48'd0, 32'sh8000_0000, 1'b0);
      send_point(48'h8000_0000_0000, -32'sd1, 1'b1);

      for (phase = 0; phase < 6; phase++) begin
         wait_drained(1'b1);
         case (phase)
            0:       r = 16'd1;
            1:       r = 16'hFFFF;
            2:       r = 16'd0;
            5:       r = RATIO_RESET;
            default: r = RATIO_BITS'($urandom_range(1, 65535));
         endcase
         write_ratio(r);
         phase_start = points_sent;
         while (points_sent - phase_start < PHASE_POINTS) run_series();
      end

      wait_drained(1'b1);
      $display("sent %0d points: directed cases plus %0d random series over 6 ratio settings",
               points_sent, series_count);
      $display("checked %0d key points, %0d mismatches", key_model.keys_checked,
               key_model.mismatches);
      if (key_model.mismatches == 0 && key_model.pending.size() == 0) begin
         $display("** piecewise_linear_compressor: PASSED **");
      end else begin
         $display("** piecewise_linear_compressor: FAILED **");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("timeout with %0d key points outstanding", key_model.pending.size());
      $display("** piecewise_linear_compressor: FAILED **");
      $finish;
   end

endmodule
